FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the retry slot table.
// Depends on nothing; files that check their logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a rising edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/rstab_pkg.sv
// Shared types and constants of the retry slot table.
// No dependencies; imported by the controller, the datapath and the top level.
package rstab_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd5000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd3;

  typedef enum logic [0:0] {
    ACT_ENQUEUE = 1'b0,
    ACT_TICK    = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OUT_NONE      = 2'd0,
    OUT_FREED     = 2'd1,
    OUT_RESCHED   = 2'd2,
    OUT_EXHAUSTED = 2'd3
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RETRY_INTERVAL = 1'd0,
    REG_MAX_ATTEMPTS   = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_TICK
  } ctrl_state_e;

  typedef struct packed {
    logic        action;
    logic [31:0] employee_id;
    logic [15:0] sensor_slot;
    logic [31:0] now_ms;
    logic        attempt_ok;
  } item_t;

  typedef struct packed {
    logic        enqueue_accepted;
    logic        attempt_made;
    logic [2:0]  entry_index;
    logic [31:0] target_employee;
    logic [15:0] target_slot;
    logic [7:0]  attempt_number;
    outcome_e    outcome;
  } result_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [31:0] employee;
    logic [15:0] slot;
    logic [7:0]  attempts;
    logic [31:0] due_ms;
  } entry_t;

  typedef struct packed {
    logic load;     // latch the accepted item
    logic enq_chk;  // test the valid bit at the scan index
    logic enq_end;  // scan ran past the last entry, refuse the job
    logic rd_en;    // read the entry memory at the scan index
    logic eval_en;  // judge the entry read in the previous cycle
    logic tick_end; // last entry judged this cycle
  } cmd_t;

  typedef struct packed {
    logic enq_hit;
    logic tick_hit;
  } sts_t;

endpackage

FILE: hw/rtl/retry_slot_table.sv
// Top level of the retry slot table: controller, datapath and checks.
// Depends on rstab_pkg, rstab_ctrl, rstab_dp and assert_macros.svh.
//
// A table of ENTRY_COUNT pending jobs. Present an item on item_i with start;
// it transfers at the rising edge where start is high and busy is low.
// An enqueue takes the lowest free entry (due at once) or is refused when the
// table is full. A tick attempts the lowest valid entry that is due by a
// wrapping signed compare of now_ms, then frees, reschedules or exhausts it.
// Every item yields exactly one result: done_o is high for one cycle and
// result_o transfers at the edge that ends it; the receiver cannot stall.
// A scan stops at the first free entry for an enqueue, or at the first due
// one for a tick, where each entry is read into a register and then judged;
// it ends past the last entry when none fits. The scan visits one entry a
// cycle, a tick scan through the single read port of the entry memory; busy
// drops with the strobe, so the next item may transfer in that same cycle.
// Configuration writes on cfg_valid_i are always ready and should only be
// made while the block is idle. Reset clears every entry valid bit and loads
// retry_interval_ms = 5000 and max_attempts = 3; entries need no clear pass.
`include "assert_macros.svh"

module retry_slot_table
  import rstab_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item_i,
  output logic                   done_o,
  output result_t                result_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IdxW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  cmd_t            cmd;
  sts_t            sts;
  logic [IdxW-1:0] scan_idx;
  logic            is_tick;
  logic            cfg_we;

  // Always take config writes; software must keep them to idle periods, which the block does not enforce.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign is_tick     = (item_i.action == ACT_TICK);

  rstab_ctrl #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .tick_i  (is_tick),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .idx_o   (scan_idx),
    .busy_o  (busy)
  );

  rstab_dp #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .idx_i       (scan_idx),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  // An accepted item must start a scan in the next cycle.
  `ASSERT_CLK(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy, "scan did not start")
  // The strobe marks the end of a scan: the controller is idle with it.
  `ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_o && busy, "result while scanning")
  // One result per item: two strobes never come back to back.
  `ASSERT_CLK(a_one_result, clk_i, rst_ni, done_o |=> !done_o, "repeated result")
  // Enqueue and tick hits never coincide within one scan cycle.
  `ASSERT_NEVER(a_hit_excl, clk_i, rst_ni, sts.enq_hit && sts.tick_hit, "two hits at once")

endmodule

FILE: hw/rtl/rstab_ctrl.sv
// Scan controller of the retry slot table: state machine and entry counter.
// Depends on rstab_pkg; drives the datapath through cmd_t and reads sts_t.
module rstab_ctrl
  import rstab_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   tick_i,
  input  sts_t                   sts_i,
  output cmd_t                   cmd_o,
  output logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] idx_o,
  output logic                   busy_o
);

  localparam int unsigned IdxW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned CntW = $clog2(ENTRY_COUNT + 1);

  ctrl_state_e       state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              cnt_end;

  assign cnt_end = (cnt_q == CntW'(ENTRY_COUNT));
  assign idx_o   = cnt_q[IdxW-1:0];
  assign busy_o  = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CntW'(1);
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = tick_i ? ST_TICK : ST_ENQ;
        end
      end
      ST_ENQ: begin
        if (sts_i.enq_hit || cnt_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (sts_i.tick_hit || cnt_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_ENQ: begin
        cmd_o.enq_chk = !cnt_end;
        cmd_o.enq_end = cnt_end;
      end
      ST_TICK: begin
        cmd_o.rd_en    = !cnt_end;
        cmd_o.eval_en  = (cnt_q != '0);
        cmd_o.tick_end = cnt_end;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/rstab_dp.sv
// Datapath of the retry slot table: entry memory, valid bits, config and result register.
// Depends on rstab_pkg; sequenced by rstab_ctrl through cmd_t.
module rstab_dp
  import rstab_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  item_t                  item_i,
  input  cmd_t                   cmd_i,
  input  logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] idx_i,
  output sts_t                   sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output result_t                result_o
);

  localparam int unsigned IdxW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  logic [ENTRY_COUNT-1:0] valid_q, valid_d;
  item_t                  item_q;
  logic [31:0]            interval_q;
  logic [7:0]             max_att_q;
  entry_t                 mem_q [ENTRY_COUNT];
  entry_t                 rd_q;
  logic [IdxW-1:0]        rd_idx_q;
  result_t                result_q, result_d;
  logic                   done_q, done_d;

  logic                   enq_hit, tick_hit, drop;
  logic [31:0]            age;
  logic [7:0]             next_att;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_idx;
  entry_t                 wr_data;
  logic [IdxW+2:0]        enq_ext, rd_ext;

  assign enq_ext  = {3'b000, idx_i};
  assign rd_ext   = {3'b000, rd_idx_q};
  assign age      = item_q.now_ms - rd_q.due_ms;
  assign next_att = rd_q.attempts + 8'd1;

  assign enq_hit  = cmd_i.enq_chk && !valid_q[idx_i];
  assign tick_hit = cmd_i.eval_en && valid_q[rd_idx_q] && !age[31];
  assign drop     = item_q.attempt_ok || (next_att >= max_att_q);

  assign sts_o.enq_hit  = enq_hit;
  assign sts_o.tick_hit = tick_hit;

  always_comb begin
    wr_en  = enq_hit || tick_hit;
    wr_idx = enq_hit ? idx_i : rd_idx_q;
    if (enq_hit) begin
      wr_data.employee = item_q.employee_id;
      wr_data.slot     = item_q.sensor_slot;
      wr_data.attempts = 8'd0;
      wr_data.due_ms   = item_q.now_ms;
    end else begin
      wr_data.employee = rd_q.employee;
      wr_data.slot     = rd_q.slot;
      wr_data.attempts = next_att;
      wr_data.due_ms   = item_q.now_ms + interval_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (enq_hit) begin
      valid_d[idx_i] = 1'b1;
    end
    if (tick_hit && drop) begin
      valid_d[rd_idx_q] = 1'b0;
    end
  end

  always_comb begin
    result_d = '0;
    done_d   = 1'b0;
    if (enq_hit) begin
      result_d.enqueue_accepted = 1'b1;
      result_d.entry_index      = enq_ext[2:0];
      done_d                    = 1'b1;
    end
    if (cmd_i.enq_end) begin
      done_d = 1'b1;
    end
    if (tick_hit) begin
      result_d.attempt_made    = 1'b1;
      result_d.entry_index     = rd_ext[2:0];
      result_d.target_employee = rd_q.employee;
      result_d.target_slot     = rd_q.slot;
      result_d.attempt_number  = next_att;
      if (item_q.attempt_ok) begin
        result_d.outcome = OUT_FREED;
      end else if (drop) begin
        result_d.outcome = OUT_EXHAUSTED;
      end else begin
        result_d.outcome = OUT_RESCHED;
      end
      done_d = 1'b1;
    end
    if (cmd_i.tick_end && !tick_hit) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem_q[idx_i];
      rd_idx_q <= idx_i;
    end
    if (done_d) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      done_q     <= 1'b0;
      interval_q <= RETRY_INTERVAL_RST;
      max_att_q  <= MAX_ATTEMPTS_RST;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RETRY_INTERVAL: interval_q <= cfg_data_i;
          REG_MAX_ATTEMPTS:   max_att_q  <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
